// ===== rtl/core/hrlf_pkg.sv =====
`default_nettype none

package hrlf_pkg;

   // Frame geometry.
   localparam int unsigned PIXELS = 32;
   localparam int unsigned IDX_W  = $clog2(PIXELS + 1);

   // Hue is in 1/64 degree units, saturation and value are Q0.8.
   localparam int unsigned HUE_W      = 15;
   localparam int unsigned Q_W        = 9;
   localparam int unsigned HUE_FULL   = 23040;
   localparam int unsigned HUE_SECTOR = 3840;
   localparam int unsigned Q_ONE      = 256;
   localparam int unsigned HUE_STEP   = HUE_FULL / PIXELS;

   // Fraction numerators are scaled by Q_ONE * HUE_SECTOR.
   localparam int unsigned NUM_FULL = Q_ONE * HUE_SECTOR;
   localparam int unsigned NUM_W    = 20;
   localparam int unsigned PROD_W   = 28;

   localparam logic [31:0] HEADER_WORD = 32'((PIXELS * 24 - 1) << 8);

   typedef struct packed {
      logic [HUE_W-1:0] hue_start;
      logic [Q_W-1:0]   saturation;
      logic [Q_W-1:0]   brightness;
   } req_type;

   typedef struct packed {
      logic [31:0] pixel_word;
      logic        last_word;
   } rsp_type;

   // One word of work handed from the sequencer to the color pipeline.
   typedef struct packed {
      logic             header;
      logic             last;
      logic [HUE_W-1:0] hue;
      logic [Q_W-1:0]   sat;
      logic [Q_W-1:0]   val;
   } token_type;

   typedef struct packed {
      logic             busy;
      logic             final_beat;
      logic [IDX_W-1:0] index;
   } seq_status_type;

endpackage

`default_nettype wire

// ===== rtl/core/hrlf_seq.sv =====
`default_nettype none

module hrlf_seq (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_valid,
   output logic                     req_ready,
   input  wire hrlf_pkg::req_type   req_data,
   input  wire                      advance,
   output logic                     token_valid,
   output hrlf_pkg::token_type      token,
   output hrlf_pkg::seq_status_type status
);
   import hrlf_pkg::*;

   logic             busy_ff, busy_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [HUE_W-1:0] hue_ff, hue_in;
   logic [Q_W-1:0]   sat_ff, sat_in;
   logic [Q_W-1:0]   val_ff, val_in;

   logic             final_beat;
   logic             issue;
   logic [HUE_W:0]   hue_sum;

   assign final_beat = busy_ff && (idx_ff == IDX_W'(PIXELS));
   assign issue      = busy_ff && advance;
   assign req_ready  = !busy_ff || (issue && final_beat);
   assign hue_sum    = {1'b0, hue_ff} + (HUE_W + 1)'(HUE_STEP);

   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      hue_in  = hue_ff;
      sat_in  = sat_ff;
      val_in  = val_ff;
      if (issue) begin
         idx_in = idx_ff + IDX_W'(1);
         // The header beat leaves the hue alone; each pixel beat steps it.
         if (idx_ff != '0) begin
            hue_in = (hue_sum >= (HUE_W + 1)'(HUE_FULL)) ? '0 : hue_sum[HUE_W-1:0];
         end
         if (final_beat) begin
            busy_in = 1'b0;
         end
      end
      if (req_valid && req_ready) begin
         busy_in = 1'b1;
         idx_in  = '0;
         hue_in  = req_data.hue_start;
         sat_in  = (req_data.saturation > Q_W'(Q_ONE)) ? Q_W'(Q_ONE) : req_data.saturation;
         val_in  = (req_data.brightness > Q_W'(Q_ONE)) ? Q_W'(Q_ONE) : req_data.brightness;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
      hue_ff <= hue_in;
      sat_ff <= sat_in;
      val_ff <= val_in;
   end

   assign token_valid       = busy_ff;
   assign token.header      = (idx_ff == '0);
   assign token.last        = final_beat;
   assign token.hue         = hue_ff;
   assign token.sat         = sat_ff;
   assign token.val         = val_ff;

   assign status.busy       = busy_ff;
   assign status.final_beat = final_beat;
   assign status.index      = idx_ff;

endmodule

`default_nettype wire

// ===== rtl/core/hrlf_conv.sv =====
`default_nettype none

module hrlf_conv (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      token_valid,
   input  wire hrlf_pkg::token_type token,
   output logic                     advance,
   output logic                     rsp_valid,
   input  wire                      rsp_ready,
   output hrlf_pkg::rsp_type        rsp_data
);
   import hrlf_pkg::*;

   typedef enum logic [2:0] {
      SECTOR_0 = 3'd0,
      SECTOR_1 = 3'd1,
      SECTOR_2 = 3'd2,
      SECTOR_3 = 3'd3,
      SECTOR_4 = 3'd4,
      SECTOR_5 = 3'd5
   } sector_type;

   // floor(255 * x / (15 * 2^24)) reduces to (17 * x) >> 24.
   function automatic logic [7:0] chan(input logic [PROD_W-1:0] x);
      logic [31:0] m;
      m = 32'(x) + (32'(x) << 4);
      return m[31:24];
   endfunction

   // Stage 1: sector and remainder.
   logic             v1_ff, hdr1_ff, last1_ff;
   sector_type       sec1_ff, sec1_in;
   logic [11:0]      rem1_ff, rem1_in;
   logic [Q_W-1:0]   sat1_ff, val1_ff;

   logic [HUE_W-1:0] h_norm;
   logic [HUE_W-1:0] base;
   logic [3:0]       k;
   logic [HUE_W-1:0] rem_wide;

   // Stage 2: fraction numerators.
   logic             v2_ff, hdr2_ff, last2_ff;
   sector_type       sec2_ff;
   logic [Q_W-1:0]   val2_ff;
   logic [NUM_W-1:0] np2_ff, nq2_ff, nt2_ff;

   logic [20:0]      sr_prod, st_prod, np_wide;
   logic [11:0]      rem_comp;
   logic [Q_W-1:0]   sat_comp;

   // Stage 3: value products.
   logic              v3_ff, hdr3_ff, last3_ff;
   sector_type        sec3_ff;
   logic [PROD_W-1:0] pv3_ff, pp3_ff, pq3_ff, pt3_ff;
   logic [PROD_W:0]   pv_wide, pp_wide, pq_wide, pt_wide;

   // Stage 4: output register.
   logic              v4_ff;
   rsp_type           out_ff, out_in;
   logic [7:0]        cv, cp, cq, ct, r, g, b;

   assign advance = !v4_ff || rsp_ready;

   always_comb begin
      h_norm = (token.hue == HUE_W'(HUE_FULL)) ? '0 : token.hue;
      k      = '0;
      base   = '0;
      for (int j = 1; j <= 8; j++) begin
         if (h_norm >= HUE_W'(j * HUE_SECTOR)) begin
            k    = 4'(j);
            base = HUE_W'(j * HUE_SECTOR);
         end
      end
      rem_wide = h_norm - base;
      rem1_in  = rem_wide[11:0];
      sec1_in  = (k >= 4'd5) ? SECTOR_5 : sector_type'(k[2:0]);
   end

   always_comb begin
      rem_comp = 12'(HUE_SECTOR) - rem1_ff;
      sat_comp = Q_W'(Q_ONE) - sat1_ff;
      sr_prod  = 21'(sat1_ff) * 21'(rem1_ff);
      st_prod  = 21'(sat1_ff) * 21'(rem_comp);
      np_wide  = 21'(sat_comp) * 21'(HUE_SECTOR);
   end

   always_comb begin
      pv_wide = (PROD_W + 1)'(val2_ff) * (PROD_W + 1)'(NUM_FULL);
      pp_wide = (PROD_W + 1)'(val2_ff) * (PROD_W + 1)'(np2_ff);
      pq_wide = (PROD_W + 1)'(val2_ff) * (PROD_W + 1)'(nq2_ff);
      pt_wide = (PROD_W + 1)'(val2_ff) * (PROD_W + 1)'(nt2_ff);
   end

   always_comb begin
      cv = chan(pv3_ff);
      cp = chan(pp3_ff);
      cq = chan(pq3_ff);
      ct = chan(pt3_ff);
      unique case (sec3_ff)
         SECTOR_0: begin r = cv; g = ct; b = cp; end
         SECTOR_1: begin r = cq; g = cv; b = cp; end
         SECTOR_2: begin r = cp; g = cv; b = ct; end
         SECTOR_3: begin r = cp; g = cq; b = cv; end
         SECTOR_4: begin r = ct; g = cp; b = cv; end
         default:  begin r = cv; g = cp; b = cq; end
      endcase
      out_in.pixel_word = hdr3_ff ? HEADER_WORD : {g, r, b, 8'h00};
      out_in.last_word  = last3_ff && !hdr3_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= token_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
      if (advance) begin
         hdr1_ff  <= token.header;
         last1_ff <= token.last;
         sec1_ff  <= sec1_in;
         rem1_ff  <= rem1_in;
         sat1_ff  <= token.sat;
         val1_ff  <= token.val;

         hdr2_ff  <= hdr1_ff;
         last2_ff <= last1_ff;
         sec2_ff  <= sec1_ff;
         val2_ff  <= val1_ff;
         np2_ff   <= np_wide[NUM_W-1:0];
         nq2_ff   <= NUM_W'(NUM_FULL) - sr_prod[NUM_W-1:0];
         nt2_ff   <= NUM_W'(NUM_FULL) - st_prod[NUM_W-1:0];

         hdr3_ff  <= hdr2_ff;
         last3_ff <= last2_ff;
         sec3_ff  <= sec2_ff;
         pv3_ff   <= pv_wide[PROD_W-1:0];
         pp3_ff   <= pp_wide[PROD_W-1:0];
         pq3_ff   <= pq_wide[PROD_W-1:0];
         pt3_ff   <= pt_wide[PROD_W-1:0];

         out_ff   <= out_in;
      end
   end

   assign rsp_valid = v4_ff;
   assign rsp_data  = out_ff;

endmodule

`default_nettype wire

// ===== rtl/core/hsv_rainbow_led_frame_core.sv =====
`default_nettype none

// LED frame generator for a serial RGB LED chain. Each request beat carries a
// start hue (1/64 degree units), a saturation and a value (Q0.8, 256 is full
// scale; larger values are clamped to 256). For each request the block sends
// one header beat holding (PIXELS*24-1)<<8 and then PIXELS pixel beats packed
// as G<<24 | R<<16 | B<<8, the last one flagged by last_word. Hue steps by
// floor(23040/PIXELS) per pixel and drops to zero once it reaches 360 degrees.
// The block sends one beat per cycle unless the result port stalls, so a
// request yields PIXELS+1 beats (33 at the default); the sequencer issues
// one word per cycle while the pipeline advances. The next request is taken
// in the cycle the sequencer issues the final pixel of the current frame, so
// frames stream without gaps. A word reaches the result port through a
// four-stage color pipeline; a stall at the result port freezes the whole
// pipeline and the sequencer together, so nothing is lost or sent twice.
module hsv_rainbow_led_frame_core (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   output logic                    req_ready,
   input  wire hrlf_pkg::req_type  req_data,
   output logic                    rsp_valid,
   input  wire                     rsp_ready,
   output hrlf_pkg::rsp_type       rsp_data
);
   import hrlf_pkg::*;

   // The sequencer hands work to the pipeline only in cycles where the
   // pipeline can move, so the pipeline's advance signal doubles as the
   // sequencer's ready.
   logic           advance;
   logic           token_valid;
   token_type      token;
   seq_status_type status;

   hrlf_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .advance     (advance),
      .token_valid (token_valid),
      .token       (token),
      .status      (status)
   );

   // Stage one finds the sector and remainder, stage two forms the fraction
   // numerators, stage three scales them by the value, and stage four turns
   // them into channel bytes and packs the word.
   hrlf_conv u_conv (
      .clock       (clock),
      .reset       (reset),
      .token_valid (token_valid),
      .token       (token),
      .advance     (advance),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

   // A new request may only overlap a frame when its final pixel is leaving.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && status.busy) |-> (status.final_beat && advance))
      else $error("request taken while a frame was still in progress");

   // While the pipeline is frozen the sequencer must not move on.
   assert property (@(posedge clock) disable iff (reset)
      (!advance && !(req_valid && req_ready)) |=> $stable(status.index))
      else $error("sequencer moved during a stall");

   // The pixel counter never runs past the end of the frame.
   assert property (@(posedge clock) disable iff (reset)
      status.busy |-> (status.index <= IDX_W'(PIXELS)))
      else $error("pixel counter out of range");

endmodule

`default_nettype wire
